>>> design/ipd_pkg.sv
// Shared types and constants for the ISP packet deframer.
package ipd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam int unsigned HEADER_LEN = 6;

  localparam logic [1:0] FUNC_BYTE = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_ARM  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_PROTOCOL = 2'd2;
  localparam logic [1:0] ST_CHECKSUM = 2'd3;

  localparam logic [1:0] CFG_EXPECTED_CMD  = 2'd0;
  localparam logic [1:0] CFG_COPY_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned LEN_OUT_W  = 6;
  localparam int unsigned TICK_W     = 24;

  localparam logic [LEN_OUT_W-1:0] COPY_LIMIT_RST = 6'd60;
  localparam logic [TICK_W-1:0]    TIMEOUT_RST    = 24'd1000;
  localparam logic [TICK_W-1:0]    TICK_MAX       = 24'hFFFFFF;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } ipd_in_t;

  typedef struct packed {
    logic [7:0]           payload_byte;
    logic                 has_byte;
    logic                 is_last;
    logic [1:0]           status;
    logic [LEN_OUT_W-1:0] data_length;
  } ipd_out_t;

endpackage

>>> design/ipd_stream_if.sv
// Valid/ready channel interfaces for the deframer input and result streams.
interface ipd_in_if;
  logic             valid;
  logic             ready;
  ipd_pkg::ipd_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ipd_out_if;
  logic              valid;
  logic              ready;
  ipd_pkg::ipd_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/isp_packet_deframer.sv
// Receives framed bytes, checks header and checksum, and drains the payload buffer.
// One input item is taken per cycle while the block is idle and its output register is
// free or being emptied. A good packet then drains min(length, copy_limit) payload
// results from the payload memory through a registered read, one per cycle while the
// output is not stalled, and then one status result; no input is taken during that
// drain. An error gives a single status result straight from the accepting cycle.
// Payload RAM holds MAX_PAYLOAD bytes and needs no clearing.
module isp_packet_deframer #(
  parameter int unsigned MAX_PAYLOAD = 60
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ipd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ipd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  ipd_in_if.sink                             rx_i,
  ipd_out_if.source                          res_o
);

  localparam int unsigned ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned BC_W   = (CNT_W > 3) ? CNT_W : 3;
  localparam int unsigned LW     = ipd_pkg::LEN_OUT_W;
  localparam int unsigned TW     = ipd_pkg::TICK_W;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;
  localparam logic PH_HDR  = 1'b0;
  localparam logic PH_PAY  = 1'b1;

  logic [7:0]        exp_cmd_q;
  logic [LW-1:0]     copy_lim_q;
  logic [TW-1:0]     timeout_q;

  logic              state_q, state_d;
  logic              armed_q, armed_d;
  logic              phase_q, phase_d;
  logic [BC_W-1:0]   bc_q, bc_d;
  logic [7:0]        sum_q, sum_d;
  logic [TW-1:0]     tick_q, tick_d;
  logic [7:0]        hdr_q [ipd_pkg::HEADER_LEN];
  logic [7:0]        hdr_d [ipd_pkg::HEADER_LEN];

  logic [7:0]        mem [MAX_PAYLOAD];
  logic [7:0]        rd_data_q;
  logic              rd_pend_q, rd_pend_d;
  logic [ADDR_W-1:0] rd_addr_q, rd_addr_d;
  logic [LW-1:0]     rd_left_q, rd_left_d;
  logic [LW-1:0]     fin_len_q, fin_len_d;

  logic              out_valid_q, out_valid_d;
  ipd_pkg::ipd_out_t out_q, out_d;

  logic              out_free, in_ready, accept, mem_we, mem_re, load, issue, err;
  logic [1:0]        err_code;
  logic [15:0]       len, len_new;
  logic [15:0]       n_cnt;
  logic [TW-1:0]     limit, tick_n;
  logic [7:0]        b;

  assign out_free = !out_valid_q || res_o.ready;
  assign in_ready = (state_q == S_IDLE) && out_free;
  assign accept   = rx_i.valid && in_ready;
  assign b        = rx_i.data.rx_byte;
  assign len      = {hdr_q[5], hdr_q[4]};
  assign len_new  = {b, hdr_q[4]};
  assign n_cnt    = (16'(copy_lim_q) < len) ? 16'(copy_lim_q) : len;
  assign limit    = (timeout_q == '0) ? TW'(1) : timeout_q;
  assign tick_n   = (tick_q < ipd_pkg::TICK_MAX) ? tick_q + TW'(1) : tick_q;

  assign rx_i.ready  = in_ready;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  always_comb begin
    state_d     = state_q;
    armed_d     = armed_q;
    phase_d     = phase_q;
    bc_d        = bc_q;
    sum_d       = sum_q;
    tick_d      = tick_q;
    hdr_d       = hdr_q;
    rd_pend_d   = rd_pend_q;
    rd_addr_d   = rd_addr_q;
    rd_left_d   = rd_left_q;
    fin_len_d   = fin_len_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    load        = 1'b0;
    issue       = 1'b0;
    err         = 1'b0;
    err_code    = ipd_pkg::ST_OK;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (rx_i.data.func)
            ipd_pkg::FUNC_ARM: begin
              armed_d = 1'b1;
              phase_d = PH_HDR;
              bc_d    = '0;
              sum_d   = '0;
              tick_d  = '0;
            end
            ipd_pkg::FUNC_BYTE: begin
              if (armed_q) begin
                if (phase_q == PH_HDR) begin
                  for (int i = 0; i < ipd_pkg::HEADER_LEN; i++) begin
                    if (bc_q[2:0] == 3'(i)) hdr_d[i] = b;
                  end
                  bc_d = bc_q + BC_W'(1);
                  if (bc_q >= BC_W'(2)) sum_d = sum_q + b;
                  if (bc_q == BC_W'(ipd_pkg::HEADER_LEN - 1)) begin
                    if (hdr_q[0] != ipd_pkg::SYNC_FIRST || hdr_q[1] != ipd_pkg::SYNC_SECOND ||
                        hdr_q[2] != exp_cmd_q || len_new > 16'(MAX_PAYLOAD)) begin
                      err      = 1'b1;
                      err_code = ipd_pkg::ST_PROTOCOL;
                    end else begin
                      phase_d = PH_PAY;
                      bc_d    = '0;
                      tick_d  = '0;
                    end
                  end
                end else if (16'(bc_q) < len) begin
                  mem_we = 1'b1;
                  bc_d   = bc_q + BC_W'(1);
                  sum_d  = sum_q + b;
                end else if (b != sum_q) begin
                  err      = 1'b1;
                  err_code = ipd_pkg::ST_CHECKSUM;
                end else begin
                  armed_d   = 1'b0;
                  state_d   = S_DRAIN;
                  rd_left_d = n_cnt[LW-1:0];
                  rd_addr_d = '0;
                  fin_len_d = len[LW-1:0];
                end
              end
            end
            ipd_pkg::FUNC_TICK: begin
              if (armed_q) begin
                tick_d = tick_n;
                if (tick_n >= limit) begin
                  err      = 1'b1;
                  err_code = ipd_pkg::ST_TIMEOUT;
                end
              end
            end
            default: ;
          endcase
        end
        if (err) begin
          armed_d           = 1'b0;
          out_valid_d       = 1'b1;
          out_d.payload_byte = '0;
          out_d.has_byte    = 1'b0;
          out_d.is_last     = 1'b1;
          out_d.status      = err_code;
          out_d.data_length = '0;
        end
      end
      S_DRAIN: begin
        load  = rd_pend_q && out_free;
        issue = (rd_left_q != '0) && (!rd_pend_q || load);
        if (issue) begin
          mem_re    = 1'b1;
          rd_left_d = rd_left_q - LW'(1);
          rd_addr_d = rd_addr_q + ADDR_W'(1);
        end
        rd_pend_d = issue || (rd_pend_q && !load);
        if (load) begin
          out_valid_d        = 1'b1;
          out_d.payload_byte = rd_data_q;
          out_d.has_byte     = 1'b1;
          out_d.is_last      = 1'b0;
          out_d.status       = ipd_pkg::ST_OK;
          out_d.data_length  = fin_len_q;
        end else if (rd_left_q == '0 && !rd_pend_q && out_free) begin
          out_valid_d        = 1'b1;
          out_d.payload_byte = '0;
          out_d.has_byte     = 1'b0;
          out_d.is_last      = 1'b1;
          out_d.status       = ipd_pkg::ST_OK;
          out_d.data_length  = fin_len_q;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_cmd_q   <= '0;
      copy_lim_q  <= ipd_pkg::COPY_LIMIT_RST;
      timeout_q   <= ipd_pkg::TIMEOUT_RST;
      state_q     <= S_IDLE;
      armed_q     <= 1'b0;
      phase_q     <= PH_HDR;
      bc_q        <= '0;
      sum_q       <= '0;
      tick_q      <= '0;
      rd_pend_q   <= 1'b0;
      rd_addr_q   <= '0;
      rd_left_q   <= '0;
      fin_len_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ipd_pkg::CFG_EXPECTED_CMD:  exp_cmd_q  <= cfg_data_i[7:0];
          ipd_pkg::CFG_COPY_LIMIT:    copy_lim_q <= cfg_data_i[LW-1:0];
          ipd_pkg::CFG_TIMEOUT_TICKS: timeout_q  <= cfg_data_i[TW-1:0];
          default: ;
        endcase
      end
      state_q     <= state_d;
      armed_q     <= armed_d;
      phase_q     <= phase_d;
      bc_q        <= bc_d;
      sum_q       <= sum_d;
      tick_q      <= tick_d;
      rd_pend_q   <= rd_pend_d;
      rd_addr_q   <= rd_addr_d;
      rd_left_q   <= rd_left_d;
      fin_len_q   <= fin_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    out_q <= out_d;
  end

  // payload buffer
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[bc_q[ADDR_W-1:0]] <= b;
    if (mem_re) rd_data_q <= mem[rd_addr_q];
  end

endmodule
